[rtl/dbd_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// dbd_pkg
// Shared types and constants for the drawing bytecode decoder: opcode fields,
// classified operations, queue entry layout and result kinds.
// ============================================================================
package dbd_pkg;

    // Byte layout
    localparam int OPERAND_BITS = 6;
    localparam int CODE_BITS    = 8;
    localparam int DEF_ACC_BITS = 32;

    // Byte count saturates here
    localparam logic [2:0] COUNT_MAX = 3'd5;

    // Entries in the front-to-back queue
    localparam int QUEUE_DEPTH = 4;

    // Top-level opcodes (bits 7..6)
    localparam logic [1:0] OPC_DX   = 2'd0;
    localparam logic [1:0] OPC_DY   = 2'd1;
    localparam logic [1:0] OPC_DATA = 2'd2;
    localparam logic [1:0] OPC_EXT  = 2'd3;

    // Extended operands
    localparam logic [5:0] EXT_PEN    = 6'd0;
    localparam logic [5:0] EXT_PAUSE  = 6'd1;
    localparam logic [5:0] EXT_CLEAR  = 6'd2;
    localparam logic [5:0] EXT_KEY    = 6'd3;
    localparam logic [5:0] EXT_COLOUR = 6'd4;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_LINE   = 3'd0,
        KIND_PAUSE  = 3'd1,
        KIND_CLEAR  = 3'd2,
        KIND_KEY    = 3'd3,
        KIND_COLOUR = 3'd4
    } t_kind;

    // Operations after classification
    typedef enum logic [3:0] {
        OP_DX,
        OP_DY,
        OP_DATA,
        OP_PEN,
        OP_PAUSE,
        OP_CLEAR,
        OP_KEY,
        OP_COLOUR,
        OP_NOP
    } t_op;

    // One queue entry
    typedef struct packed {
        t_op                     op;
        logic [OPERAND_BITS-1:0] operand;
    } t_item;

endpackage

[rtl/dbd_ifs.sv]
`timescale 1ns / 1ps
// ============================================================================
// dbd channel interfaces
// Valid/ready channels for command bytes in and drawing commands out.
// ============================================================================
interface dbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;

    modport source (output valid, output code_byte, input ready);
    modport sink   (input valid, input code_byte, output ready);
endinterface

interface dbd_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command_kind;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic [31:0]        command_value;

    modport source (output valid, output command_kind, output start_x, output start_y,
                    output end_x, output end_y, output command_value, input ready);
    modport sink   (input valid, input command_kind, input start_x, input start_y,
                    input end_x, input end_y, input command_value, output ready);
endinterface

[rtl/dbd_front.sv]
`timescale 1ns / 1ps
// ============================================================================
// dbd_front
// Accepts command bytes and classifies them into operations. Unused extended
// codes are dropped here. One registered stage toward the queue.
// ============================================================================
module dbd_front
    import dbd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    dbd_in_if.sink i_code,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_ready
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  take;

    assign take         = !r_valid || i_ready;
    assign i_code.ready = take;
    assign o_valid      = r_valid;
    assign o_item       = r_item;

    // Decode opcode and extended operand
    always_comb begin
        n_item.operand = i_code.code_byte[OPERAND_BITS-1:0];
        case (i_code.code_byte[CODE_BITS-1:OPERAND_BITS])
            OPC_DX:   n_item.op = OP_DX;
            OPC_DY:   n_item.op = OP_DY;
            OPC_DATA: n_item.op = OP_DATA;
            default: begin
                case (i_code.code_byte[OPERAND_BITS-1:0])
                    EXT_PEN:    n_item.op = OP_PEN;
                    EXT_PAUSE:  n_item.op = OP_PAUSE;
                    EXT_CLEAR:  n_item.op = OP_CLEAR;
                    EXT_KEY:    n_item.op = OP_KEY;
                    EXT_COLOUR: n_item.op = OP_COLOUR;
                    default:    n_item.op = OP_NOP;
                endcase
            end
        endcase
    end

    // Stage register; no-ops never enter the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= i_code.valid && (n_item.op != OP_NOP);
        end
        if (take) begin
            r_item <= n_item;
        end
    end

endmodule

[rtl/dbd_queue.sv]
`timescale 1ns / 1ps
// ============================================================================
// dbd_queue
// Small FIFO of classified operations between front and back. Ready depends
// only on the fill level, so the two sides stall independently.
// ============================================================================
module dbd_queue
    import dbd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_ready,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_ready
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= PTR_W'(r_wr_ptr + 1'b1);
            end
            if (pop) begin
                r_rd_ptr <= PTR_W'(r_rd_ptr + 1'b1);
            end
            case ({push, pop})
                2'b10:   r_count <= CNT_W'(r_count + 1'b1);
                2'b01:   r_count <= CNT_W'(r_count - 1'b1);
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

[rtl/dbd_back.sv]
`timescale 1ns / 1ps
// ============================================================================
// dbd_back
// Executes classified operations: accumulator and byte count, step and pen
// position, pen state, and the command output register.
// ============================================================================
module dbd_back
    import dbd_pkg::*;
#(
    parameter int ACC_BITS = DEF_ACC_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_item      i_item,
    output logic       o_ready,
    dbd_out_if.source  o_cmd
);

    // Architectural state
    logic [15:0]         r_pos_x;
    logic [15:0]         r_pos_y;
    logic [31:0]         r_step_x;
    logic [ACC_BITS-1:0] r_acc;
    logic [2:0]          r_count;
    logic                r_pen;

    logic [15:0]         n_pos_x;
    logic [15:0]         n_pos_y;
    logic [31:0]         n_step_x;
    logic [ACC_BITS-1:0] n_acc;
    logic [2:0]          n_count;
    logic                n_pen;

    // Output register
    logic        r_out_valid;
    t_kind       r_kind;
    logic [15:0] r_sx;
    logic [15:0] r_sy;
    logic [15:0] r_ex;
    logic [15:0] r_ey;
    logic [31:0] r_value;

    t_kind       n_kind;
    logic [15:0] n_sx;
    logic [15:0] n_sy;
    logic [15:0] n_ex;
    logic [15:0] n_ey;
    logic [31:0] n_value;
    logic        emit;

    logic [ACC_BITS-1:0] acc_sh;
    logic [63:0]         acc_ext;
    logic [2:0]          cnt_sh;
    logic                sign;
    logic [31:0]         span;
    logic [31:0]         sval;
    logic [31:0]         acc_lo;
    logic [15:0]         nx;
    logic [15:0]         ny;
    logic                out_free;
    logic                fire;

    assign out_free = !r_out_valid || o_cmd.ready;
    assign o_ready  = !emit || out_free;
    assign fire     = i_valid && o_ready;

    // Shift operand in, then read as signed value of 6 * count bits
    always_comb begin
        acc_sh  = ACC_BITS'({r_acc, i_item.operand});
        acc_ext = 64'(acc_sh);
        cnt_sh  = (r_count < COUNT_MAX) ? 3'(r_count + 3'd1) : COUNT_MAX;
        case (cnt_sh)
            3'd1:    begin sign = acc_ext[5];  span = 32'h0000_0040; end
            3'd2:    begin sign = acc_ext[11]; span = 32'h0000_1000; end
            3'd3:    begin sign = acc_ext[17]; span = 32'h0004_0000; end
            3'd4:    begin sign = acc_ext[23]; span = 32'h0100_0000; end
            3'd5:    begin sign = acc_ext[29]; span = 32'h4000_0000; end
            default: begin sign = 1'b0;        span = 32'h0000_0000; end
        endcase
        sval   = 32'(acc_sh) - (sign ? span : 32'h0);
        acc_lo = 32'(r_acc);
        nx     = 16'(r_pos_x + r_step_x[15:0]);
        ny     = 16'(r_pos_y + sval[15:0]);
    end

    // Operation execution
    always_comb begin
        n_pos_x  = r_pos_x;
        n_pos_y  = r_pos_y;
        n_step_x = r_step_x;
        n_acc    = r_acc;
        n_count  = r_count;
        n_pen    = r_pen;
        emit     = 1'b0;
        n_kind   = KIND_LINE;
        n_sx     = '0;
        n_sy     = '0;
        n_ex     = '0;
        n_ey     = '0;
        n_value  = '0;
        case (i_item.op)
            OP_DX: begin
                n_step_x = sval;
                n_acc    = '0;
                n_count  = '0;
            end
            OP_DY: begin
                emit     = r_pen;
                n_kind   = KIND_LINE;
                n_sx     = r_pos_x;
                n_sy     = r_pos_y;
                n_ex     = nx;
                n_ey     = ny;
                n_pos_x  = nx;
                n_pos_y  = ny;
                n_step_x = '0;
                n_acc    = '0;
                n_count  = '0;
            end
            OP_DATA: begin
                n_acc   = acc_sh;
                n_count = cnt_sh;
            end
            OP_PEN: begin
                n_pen = !r_pen;
            end
            OP_PAUSE: begin
                // delay goes straight to the command; count is kept
                emit    = 1'b1;
                n_kind  = KIND_PAUSE;
                n_value = acc_lo;
                n_acc   = '0;
            end
            OP_CLEAR: begin
                emit    = 1'b1;
                n_kind  = KIND_CLEAR;
                n_acc   = '0;
                n_count = '0;
            end
            OP_KEY: begin
                emit   = 1'b1;
                n_kind = KIND_KEY;
            end
            OP_COLOUR: begin
                emit    = 1'b1;
                n_kind  = KIND_COLOUR;
                n_value = acc_lo;
                n_acc   = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    // State and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_step_x    <= '0;
            r_acc       <= '0;
            r_count     <= '0;
            r_pen       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_pos_x  <= n_pos_x;
                r_pos_y  <= n_pos_y;
                r_step_x <= n_step_x;
                r_acc    <= n_acc;
                r_count  <= n_count;
                r_pen    <= n_pen;
            end
            if (out_free) begin
                r_out_valid <= fire && emit;
            end
        end
        if (out_free && fire && emit) begin
            r_kind  <= n_kind;
            r_sx    <= n_sx;
            r_sy    <= n_sy;
            r_ex    <= n_ex;
            r_ey    <= n_ey;
            r_value <= n_value;
        end
    end

    assign o_cmd.valid         = r_out_valid;
    assign o_cmd.command_kind  = r_kind;
    assign o_cmd.start_x       = r_sx;
    assign o_cmd.start_y       = r_sy;
    assign o_cmd.end_x         = r_ex;
    assign o_cmd.end_y         = r_ey;
    assign o_cmd.command_value = r_value;

endmodule

[rtl/drawing_bytecode_decoder.sv]
`timescale 1ns / 1ps
// ============================================================================
// drawing_bytecode_decoder
// Interpreter for a byte-coded drawing stream.
//
// Channels: i_code carries one command byte per transaction; o_cmd carries
// one drawing command (line, pause, clear, wait for key, colour) per
// transaction. Bytes that produce no command (data, dx, dy with pen up, pen, unused codes)
// are absorbed silently.
// Throughput: one byte per cycle sustained while o_cmd stays ready; the execute
// unit retires one operation per cycle while the output register is free.
// Path: with no stalls a command reaches o_cmd through the classify register,
// a queue entry and the output register after the edge that takes its byte.
// Stall: when o_cmd is held off, the output register keeps its command and
// the back end keeps retiring bytes that produce none until one that does
// reaches it; that byte and all behind it wait in the four-entry queue, and
// i_code drops ready once queue and classify stage are full.
// Reset: synchronous, active low; clears position, step, accumulator, count,
// pen (up) and empties queue and output.
// ============================================================================
module drawing_bytecode_decoder
    import dbd_pkg::*;
#(
    parameter int ACC_BITS = DEF_ACC_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dbd_in_if.sink    i_code,
    dbd_out_if.source o_cmd
);

    logic  f_valid;
    t_item f_item;
    logic  f_ready;
    logic  q_valid;
    t_item q_item;
    logic  q_ready;

    dbd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_code  (i_code),
        .o_valid (f_valid),
        .o_item  (f_item),
        .i_ready (f_ready)
    );

    dbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_item  (f_item),
        .o_ready (f_ready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_ready (q_ready)
    );

    dbd_back #(
        .ACC_BITS (ACC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_ready (q_ready),
        .o_cmd   (o_cmd)
    );

endmodule

[test/tb_drawing_bytecode_decoder.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_drawing_bytecode_decoder
// Self-checking bench for the drawing bytecode decoder. A table of directed
// bytes comes first: the extremes, every extended code, saturation of the
// byte count and wrapping positions. A long random stream of well-formed
// move, colour and pause sequences follows, mixed with noise. Bytes are
// interpreted by a local model at acceptance, and every command leaving the
// block is compared with the oldest expected one, from the model or the table.
// ============================================================================
module tb_drawing_bytecode_decoder;
    import dbd_pkg::*;

    localparam int RANDOM_BYTES = 650;
    localparam int DIR_ROWS     = 26;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int QUIET_TAIL   = 100;

    // One drawing command as it leaves the block
    typedef struct packed {
        t_kind       kind;
        logic [15:0] sx;
        logic [15:0] sy;
        logic [15:0] ex;
        logic [15:0] ey;
        logic [31:0] value;
    } t_draw_cmd;

    // How a directed row is checked
    typedef enum logic [1:0] {
        ROW_MODEL,  // predicted by the local model
        ROW_NONE,   // no command expected
        ROW_TYPED   // command typed into the table
    } t_row_chk;

    typedef struct packed {
        logic [7:0] code;
        t_row_chk   chk;
        t_draw_cmd  lit;
    } t_stim_row;

    localparam t_draw_cmd NO_CMD = '0;

    // Directed stimulus, walked from the top after reset
    localparam t_stim_row DIRECTED [DIR_ROWS] = '{
        // extended codes straight after reset
        '{8'hC3, ROW_TYPED, '{KIND_KEY,    16'd0, 16'd0, 16'd0, 16'd0, 32'd0}},
        '{8'hC2, ROW_TYPED, '{KIND_CLEAR,  16'd0, 16'd0, 16'd0, 16'd0, 32'd0}},
        '{8'hC1, ROW_TYPED, '{KIND_PAUSE,  16'd0, 16'd0, 16'd0, 16'd0, 32'd0}},
        '{8'hC4, ROW_TYPED, '{KIND_COLOUR, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0}},
        // six all-ones operands: count saturates, accumulator keeps 32 bits
        '{8'hBF, ROW_NONE,  NO_CMD},
        '{8'hBF, ROW_NONE,  NO_CMD},
        '{8'hBF, ROW_NONE,  NO_CMD},
        '{8'hBF, ROW_NONE,  NO_CMD},
        '{8'hBF, ROW_NONE,  NO_CMD},
        '{8'hBF, ROW_NONE,  NO_CMD},
        '{8'hC4, ROW_TYPED, '{KIND_COLOUR, 16'd0, 16'd0, 16'd0, 16'd0, 32'hFFFF_FFFF}},
        // pause takes the accumulator but keeps the count
        '{8'h81, ROW_NONE,  NO_CMD},
        '{8'hC1, ROW_TYPED, '{KIND_PAUSE,  16'd0, 16'd0, 16'd0, 16'd0, 32'd1}},
        '{8'h3F, ROW_NONE,  NO_CMD},
        // pen down, then two lines
        '{8'hC0, ROW_NONE,  NO_CMD},
        '{8'h40, ROW_TYPED, '{KIND_LINE, 16'd0, 16'd0, 16'd63, 16'd0, 32'd0}},
        '{8'h20, ROW_NONE,  NO_CMD},
        '{8'h7F, ROW_TYPED, '{KIND_LINE, 16'd63, 16'd0, 16'd31, 16'hFFFF, 32'd0}},
        // wide negative step, positions wrap
        '{8'hA0, ROW_NONE,  NO_CMD},
        '{8'hA0, ROW_NONE,  NO_CMD},
        '{8'hA0, ROW_NONE,  NO_CMD},
        '{8'h00, ROW_MODEL, NO_CMD},
        '{8'h5F, ROW_MODEL, NO_CMD},
        // unused extended code, pen up, silent move
        '{8'hFF, ROW_NONE,  NO_CMD},
        '{8'hC0, ROW_NONE,  NO_CMD},
        '{8'h41, ROW_NONE,  NO_CMD}
    };

    logic i_clk;
    logic i_rst_n;

    dbd_in_if  code_if ();
    dbd_out_if cmd_if ();

    drawing_bytecode_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_code  (code_if),
        .o_cmd   (cmd_if)
    );

    // Interpreter state
    logic [15:0] pen_x;
    logic [15:0] pen_y;
    logic [31:0] x_step;
    logic [31:0] delay_reg;
    logic [31:0] acc_reg;
    logic [2:0]  grp_cnt;
    logic        pen_is_down;

    t_draw_cmd pending_cmds[$];
    int        mismatch_cnt;
    int        bytes_fed;
    bit        src_idle_en;
    bit        sink_idle_en;
    bit        long_hold_req;

    // ------------------------------------------------------------------------
    // Interpreter
    // ------------------------------------------------------------------------
    function automatic void shift_operand(input logic [5:0] opd);
        acc_reg = (acc_reg << OPERAND_BITS) | {26'd0, opd};
        if (grp_cnt < COUNT_MAX) grp_cnt = grp_cnt + 3'd1;
    endfunction

    // Accumulator read as a two's complement number of 6 * count bits
    function automatic logic [31:0] grouped_value();
        logic [63:0] v;
        int          nb;
        nb = OPERAND_BITS * int'(grp_cnt);
        v  = {32'd0, acc_reg};
        if (v[nb-1]) v = v - (64'd1 << nb);
        return v[31:0];
    endfunction

    function automatic bit interpret_byte(input logic [7:0] code, output t_draw_cmd cmd);
        logic [5:0]  opd;
        logic [31:0] dy;
        logic [15:0] nx;
        logic [15:0] ny;
        bit          hit;
        opd = code[5:0];
        hit = 1'b0;
        cmd = NO_CMD;
        case (code[7:6])
            OPC_DX: begin
                shift_operand(opd);
                x_step  = grouped_value();
                grp_cnt = '0;
                acc_reg = '0;
            end
            OPC_DY: begin
                shift_operand(opd);
                dy = grouped_value();
                nx = pen_x + x_step[15:0];
                ny = pen_y + dy[15:0];
                if (pen_is_down) begin
                    cmd = '{KIND_LINE, pen_x, pen_y, nx, ny, 32'd0};
                    hit = 1'b1;
                end
                pen_x   = nx;
                pen_y   = ny;
                x_step  = '0;
                grp_cnt = '0;
                acc_reg = '0;
            end
            OPC_DATA: shift_operand(opd);
            default: begin
                case (opd)
                    EXT_PEN: pen_is_down = !pen_is_down;
                    EXT_PAUSE: begin
                        delay_reg = acc_reg;
                        cmd.kind  = KIND_PAUSE;
                        cmd.value = delay_reg;
                        hit       = 1'b1;
                        acc_reg   = '0;
                    end
                    EXT_CLEAR: begin
                        cmd.kind = KIND_CLEAR;
                        hit      = 1'b1;
                        grp_cnt  = '0;
                        acc_reg  = '0;
                    end
                    EXT_KEY: begin
                        cmd.kind = KIND_KEY;
                        hit      = 1'b1;
                    end
                    EXT_COLOUR: begin
                        cmd.kind  = KIND_COLOUR;
                        cmd.value = acc_reg;
                        hit       = 1'b1;
                        grp_cnt   = '0;
                        acc_reg   = '0;
                    end
                    default: ;
                endcase
            end
        endcase
        return hit;
    endfunction

    // ------------------------------------------------------------------------
    // Byte source
    // ------------------------------------------------------------------------
    task automatic feed_byte(input logic [7:0] code, input t_row_chk chk = ROW_MODEL,
                             input t_draw_cmd lit = NO_CMD);
        t_draw_cmd cmd;
        bit        hit;
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            code_if.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        code_if.valid     <= 1'b1;
        code_if.code_byte <= code;
        do @(posedge i_clk); while (!code_if.ready);
        // transaction taken at this edge
        hit = interpret_byte(code, cmd);
        case (chk)
            ROW_MODEL: if (hit) pending_cmds.push_back(cmd);
            ROW_TYPED: pending_cmds.push_back(lit);
            default: ;
        endcase
        bytes_fed++;
    endtask

    function automatic logic [7:0] ext_byte(input logic [5:0] opd);
        return {OPC_EXT, opd};
    endfunction

    task automatic feed_data(input int lo, input int hi);
        repeat ($urandom_range(lo, hi))
            feed_byte({OPC_DATA, 6'($urandom_range(0, 63))});
    endtask

    // One random sequence; mostly well formed, some noise
    task automatic feed_random_sequence();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                if ($urandom_range(0, 3) == 0) feed_byte(ext_byte(EXT_PEN));
                feed_data(0, 4);
                if ($urandom_range(0, 4) != 0) begin
                    feed_byte({OPC_DX, 6'($urandom_range(0, 63))});
                    feed_data(0, 4);
                end
                feed_byte({OPC_DY, 6'($urandom_range(0, 63))});
            end
            4: begin
                feed_data(0, 6);
                feed_byte(ext_byte(EXT_COLOUR));
            end
            5: begin
                feed_data(0, 6);
                feed_byte(ext_byte(EXT_PAUSE));
            end
            6: feed_byte(ext_byte($urandom_range(0, 1) ? EXT_CLEAR : EXT_KEY));
            7: feed_byte(ext_byte(EXT_PEN));
            8: repeat ($urandom_range(1, 4)) feed_byte(8'($urandom_range(0, 255)));
            default: begin
                // broken sequence: data cut off by an unused or clearing code
                feed_data(1, 3);
                if ($urandom_range(0, 1))
                    feed_byte(ext_byte(6'($urandom_range(5, 63))));
                else
                    feed_byte(ext_byte(EXT_CLEAR));
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Command sink: check, then decide ready for the next cycle
    // ------------------------------------------------------------------------
    task automatic check_cmd();
        t_draw_cmd exp_cmd;
        if (pending_cmds.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("unexpected command: kind %0d value %h",
                         cmd_if.command_kind, cmd_if.command_value);
            return;
        end
        exp_cmd = pending_cmds.pop_front();
        if (cmd_if.command_kind !== exp_cmd.kind || cmd_if.start_x !== exp_cmd.sx ||
            cmd_if.start_y !== exp_cmd.sy || cmd_if.end_x !== exp_cmd.ex ||
            cmd_if.end_y !== exp_cmd.ey || cmd_if.command_value !== exp_cmd.value) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("exp %0d (%0d,%0d)>(%0d,%0d) %h got %0d (%0d,%0d)>(%0d,%0d) %h",
                         exp_cmd.kind, $signed(exp_cmd.sx), $signed(exp_cmd.sy),
                         $signed(exp_cmd.ex), $signed(exp_cmd.ey), exp_cmd.value,
                         cmd_if.command_kind, cmd_if.start_x, cmd_if.start_y,
                         cmd_if.end_x, cmd_if.end_y, cmd_if.command_value);
        end
    endtask

    int hold_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) check_cmd();
            if (hold_left > 0) begin
                hold_left--;
                cmd_if.ready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD - 1;
                cmd_if.ready <= 1'b0;
            end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
                hold_left = $urandom_range(0, 16);
                cmd_if.ready <= 1'b0;
            end else begin
                cmd_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Clock, reset and stimulus
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int next_switch;
        int drain;
        int total_bytes;
        i_rst_n           = 1'b0;
        code_if.valid     = 1'b0;
        code_if.code_byte = '0;
        mismatch_cnt      = 0;
        bytes_fed         = 0;
        src_idle_en       = 1'b1;
        sink_idle_en      = 1'b1;
        long_hold_req     = 1'b0;
        pen_x             = '0;
        pen_y             = '0;
        x_step            = '0;
        delay_reg         = '0;
        acc_reg           = '0;
        grp_cnt           = '0;
        pen_is_down       = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < DIR_ROWS; r++)
            feed_byte(DIRECTED[r].code, DIRECTED[r].chk, DIRECTED[r].lit);

        // long sink hold-off while commands keep coming: queue fills up
        long_hold_req = 1'b1;
        repeat (16) feed_byte(ext_byte(EXT_KEY));

        // random stream, idling switched per block, quiet tail at the end
        total_bytes = bytes_fed + RANDOM_BYTES;
        next_switch = bytes_fed;
        while (bytes_fed < total_bytes) begin
            if (bytes_fed >= total_bytes - QUIET_TAIL) begin
                src_idle_en  = 1'b0;
                sink_idle_en = 1'b0;
            end else if (bytes_fed >= next_switch) begin
                next_switch  = bytes_fed + 60;
                src_idle_en  = $urandom_range(0, 3) != 0;
                sink_idle_en = $urandom_range(0, 3) != 0;
            end
            feed_random_sequence();
        end
        code_if.valid <= 1'b0;

        // wait for outstanding commands, then a few cycles more
        drain = 0;
        while (pending_cmds.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (20) @(posedge i_clk);
        if (pending_cmds.size() != 0) mismatch_cnt++;

        if (mismatch_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/dbd_pkg.sv
rtl/dbd_ifs.sv
rtl/dbd_front.sv
rtl/dbd_queue.sv
rtl/dbd_back.sv
rtl/drawing_bytecode_decoder.sv
test/tb_drawing_bytecode_decoder.sv
